// ===== rtl/ucar_pkg.sv =====
// ---------------------------------------------------------------------------
// ucar_pkg: shared types, constants and helpers for the uplift curve block
// Holds the fixed-point widths, the codes used by the sequencer and the
// saturating helpers that the sequencer uses.
// ---------------------------------------------------------------------------
`default_nettype none

package ucar_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WT_W      = 48;
  localparam int ACC_W     = 64;
  localparam int WIDE_W    = 128;
  localparam int DEN_W     = 2 * WT_W;
  localparam int MUL_STEPS = WT_W;
  localparam int DIV_STEPS = WIDE_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [WT_W-1:0]  WMAX     = {WT_W{1'b1}};
  localparam logic [ACC_W-1:0] INT64MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] TERM_MAX = 64'd1 << 61;

  localparam logic [1:0] TR_CONTROL = 2'd1;
  localparam logic [1:0] TR_TREATED = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TR   = 2'd1;
  localparam logic [1:0] ST_ZERO_GRP = 2'd2;
  localparam logic [1:0] ST_ORDER    = 2'd3;

  typedef enum logic {MDU_MUL, MDU_DIV} mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_ACC, S_END, S_CGO, S_CWAIT,
    S_FIN, S_FGO, S_FWAIT, S_COMB, S_EMIT
  } seq_state_t;

  function automatic logic signed [ACC_W-1:0] sat_add64(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = $signed({a[ACC_W-1], a}) + $signed({b[ACC_W-1], b});
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add64 = s[ACC_W] ? $signed(~INT64MAX) : $signed(INT64MAX);
    end else begin
      sat_add64 = s[ACC_W-1:0];
    end
  endfunction

  function automatic logic [WT_W-1:0] sat_addw(input logic [WT_W-1:0] a,
                                               input logic [WT_W-1:0] b);
    logic [WT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_addw = s[WT_W] ? WMAX : s[WT_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] mag64(input logic signed [ACC_W-1:0] x);
    mag64 = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
  endfunction

  function automatic logic signed [ACC_W-1:0] signed_of(input logic neg,
                                                       input logic [ACC_W-1:0] m);
    signed_of = neg ? $signed(ACC_W'(-m)) : $signed(m);
  endfunction

  function automatic logic [ACC_W-1:0] wclamp(input logic [WIDE_W-1:0] x,
                                              input logic [ACC_W-1:0] mx);
    wclamp = (x > WIDE_W'(mx)) ? mx : x[ACC_W-1:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] x);
    if (x > 64'sd2147483647) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ucar_mdu.sv =====
// ---------------------------------------------------------------------------
// ucar_mdu: shared shift-add multiplier and restoring divider
// One 128-bit adder serves both: a multiply takes one multiplier bit a cycle,
// a divide takes one quotient bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ucar_mdu (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ucar_pkg::mdu_req_t         req,
  input  wire logic [ucar_pkg::WIDE_W-1:0] a,
  input  wire logic [ucar_pkg::WIDE_W-1:0] b,
  output ucar_pkg::mdu_rsp_t              rsp,
  output logic [ucar_pkg::WIDE_W-1:0]     result
);
  import ucar_pkg::*;

  logic [WIDE_W-1:0] acc, x, y, rem, rs, opa, opb;
  logic [WIDE_W:0]   sum;
  logic [CNT_W-1:0]  cnt;
  logic              busy, done;
  mdu_op_t           op;

  always_comb begin
    rs  = {rem[WIDE_W-2:0], x[WIDE_W-1]};
    opa = (op == MDU_MUL) ? acc : rs;
    opb = (op == MDU_MUL) ? x : ~y;
    sum = {1'b0, opa} + {1'b0, opb} + (WIDE_W+1)'(op == MDU_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        cnt  <= (req.op == MDU_MUL) ? CNT_W'(MUL_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
        acc  <= '0;
        rem  <= '0;
        x    <= a;
        y    <= b;
      end else if (busy) begin
        if (op == MDU_MUL) begin
          if (y[0]) begin
            acc <= sum[WIDE_W-1:0];
          end
          x <= x << 1;
          y <= y >> 1;
        end else begin
          x   <= x << 1;
          acc <= {acc[WIDE_W-2:0], sum[WIDE_W]};
          rem <= sum[WIDE_W] ? sum[WIDE_W-1:0] : rs;
        end
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign result   = acc;

endmodule

`default_nettype wire

// ===== rtl/uplift_curve_area.sv =====
// ---------------------------------------------------------------------------
// uplift_curve_area: area under the uplift curve and Qini value
// Accumulates weighted examples sorted by falling uplift and reports the
// curve area and Qini value on the final word of each stream.
// ---------------------------------------------------------------------------
// Usage. Input words (pred_uplift, outcome, weight, treatment, last)
// arrive on a valid/ready channel; one result word (area, qini, status)
// leaves on a second valid/ready channel, once per stream, for the word
// marked last. The block works on one word at a time and holds in_ready low
// until it is done with it.
// Sequence. A word that stays in its tie group passes through the check,
// accumulate and end states before in_ready is high again. A word that
// opens a new tie group also closes the old one: two 48-step multiplies
// on the shared unit. A last word adds a further group close and, when no
// error is pending, two 48-step multiplies and four 128-step divides on
// that same unit, before its result is written to the output register.
// Stalls. The result sits in an output register; the next stream's words
// are taken while it waits, and only a second result must wait for it.
// Reset. rst clears all sums, the error code and out_valid.
// ---------------------------------------------------------------------------
`default_nettype none

module uplift_curve_area (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] pred_uplift,
  input  wire logic signed [23:0] outcome,
  input  wire logic [23:0]        weight,
  input  wire logic [1:0]         treatment,
  input  wire logic               last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      area,
  output logic signed [31:0]      qini,
  output logic [1:0]              status
);
  import ucar_pkg::*;

  seq_state_t state, state_next;

  // Captured input word.
  logic signed [31:0] up_r;
  logic signed [23:0] oc_r;
  logic [23:0]        w_r;
  logic [1:0]         tr_r;
  logic               last_r;
  logic signed [47:0] prod_r;

  // Stream state.
  logic [WT_W-1:0]         wt_t, wt_c, wt_all, prev_gw;
  logic signed [ACC_W-1:0] run_t, run_c, prev_t, prev_c, asum_t, asum_c;
  logic signed [31:0]      prev_up;
  logic                    have_prev;
  logic [1:0]              err;

  // Sequencer working registers.
  logic              cph, ret_last, neg_r;
  logic [2:0]        fk;
  logic [DEN_W-1:0]  den;
  logic signed [ACC_W-1:0] t_at, t_ac, t_lt, t_lc;
  logic signed [31:0] res_area, res_qini;
  logic [1:0]         res_st;

  // Shared unit.
  mdu_req_t          mreq;
  mdu_rsp_t          mrsp;
  logic [WIDE_W-1:0] ma, mb, mres;

  ucar_mdu u_mdu (
    .clk    (clk),
    .rst    (rst),
    .req    (mreq),
    .a      (ma),
    .b      (mb),
    .rsp    (mrsp),
    .result (mres)
  );

  // Combinational helpers.
  logic signed [48:0]      prod_full;
  logic [47:0]             prod_mag;
  logic signed [ACC_W-1:0] wo, cs, cstep, area_c, nl_c, half_c, qini_c;
  logic                    bad_tr, rising, new_grp, zero_grp;
  logic [1:0]              st_fin;
  logic [WT_W-1:0]         dw;
  logic                    clear_now;

  always_comb begin
    prod_full = $signed(oc_r) * $signed({1'b0, w_r});
    prod_mag  = prod_r[47] ? 48'(-prod_r) : 48'(prod_r);
    wo        = signed_of(prod_r[47], ACC_W'(prod_mag >> FRAC_BITS));
    bad_tr    = (tr_r != TR_CONTROL) && (tr_r != TR_TREATED);
    rising    = have_prev && (up_r > prev_up);
    new_grp   = have_prev && (up_r != prev_up);
    zero_grp  = (wt_t == '0) || (wt_c == '0);
    if (err != ST_OK) begin
      st_fin = err;
    end else if (zero_grp) begin
      st_fin = ST_ZERO_GRP;
    end else begin
      st_fin = ST_OK;
    end
    dw     = wt_all - prev_gw;
    cs     = cph ? sat_add64(run_c, prev_c) : sat_add64(run_t, prev_t);
    cstep  = signed_of(neg_r, wclamp(mres >> FRAC_BITS, INT64MAX));
    area_c = t_at - t_ac;
    nl_c   = t_lt - t_lc;
    half_c = (nl_c + $signed(ACC_W'(nl_c[ACC_W-1]))) >>> 1;
    qini_c = area_c - half_c;
    clear_now = ((state == S_FIN) && (st_fin != ST_OK)) || (state == S_COMB);
  end

  // Operand selection for the shared unit.
  always_comb begin
    mreq.start = 1'b0;
    mreq.op    = MDU_MUL;
    ma         = WIDE_W'(mag64(cs));
    mb         = WIDE_W'(dw);
    if (state == S_CGO) begin
      mreq.start = 1'b1;
    end else if (state == S_FGO) begin
      mreq.start = 1'b1;
      case (fk)
        3'd0: begin
          ma = WIDE_W'(wt_t);
          mb = WIDE_W'(wt_all);
        end
        3'd1: begin
          mreq.op = MDU_DIV;
          ma      = WIDE_W'(mag64(asum_t)) << (2 * FRAC_BITS - 1);
          mb      = WIDE_W'(den);
        end
        3'd2: begin
          ma = WIDE_W'(wt_c);
          mb = WIDE_W'(wt_all);
        end
        3'd3: begin
          mreq.op = MDU_DIV;
          ma      = WIDE_W'(mag64(asum_c)) << (2 * FRAC_BITS - 1);
          mb      = WIDE_W'(den);
        end
        3'd4: begin
          mreq.op = MDU_DIV;
          ma      = WIDE_W'(mag64(run_t)) << FRAC_BITS;
          mb      = WIDE_W'(wt_t);
        end
        default: begin
          mreq.op = MDU_DIV;
          ma      = WIDE_W'(mag64(run_c)) << FRAC_BITS;
          mb      = WIDE_W'(wt_c);
        end
      endcase
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (bad_tr || rising) begin
          state_next = S_END;
        end else if (new_grp) begin
          state_next = S_CGO;
        end else begin
          state_next = S_ACC;
        end
      end
      S_ACC: state_next = S_END;
      S_END: begin
        if (!last_r) begin
          state_next = S_IDLE;
        end else if (have_prev) begin
          state_next = S_CGO;
        end else begin
          state_next = S_FIN;
        end
      end
      S_CGO: state_next = S_CWAIT;
      S_CWAIT: begin
        if (mrsp.done) begin
          if (!cph) begin
            state_next = S_CGO;
          end else begin
            state_next = ret_last ? S_FIN : S_ACC;
          end
        end
      end
      S_FIN: state_next = (st_fin != ST_OK) ? S_EMIT : S_FGO;
      S_FGO: state_next = S_FWAIT;
      S_FWAIT: begin
        if (mrsp.done) begin
          state_next = (fk == 3'd5) ? S_COMB : S_FGO;
        end
      end
      S_COMB: state_next = S_EMIT;
      S_EMIT: begin
        if (!out_valid) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      wt_t      <= '0;
      wt_c      <= '0;
      wt_all    <= '0;
      prev_gw   <= '0;
      run_t     <= '0;
      run_c     <= '0;
      prev_t    <= '0;
      prev_c    <= '0;
      asum_t    <= '0;
      asum_c    <= '0;
      prev_up   <= '0;
      have_prev <= 1'b0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            up_r   <= pred_uplift;
            oc_r   <= outcome;
            w_r    <= weight;
            tr_r   <= treatment;
            last_r <= last;
          end
        end
        S_CHECK: begin
          prod_r   <= prod_full[47:0];
          cph      <= 1'b0;
          ret_last <= 1'b0;
          if (bad_tr) begin
            if (err == ST_OK) begin
              err <= ST_BAD_TR;
            end
          end else if (rising) begin
            if (err == ST_OK) begin
              err <= ST_ORDER;
            end
          end
        end
        S_ACC: begin
          if (tr_r == TR_TREATED) begin
            run_t <= sat_add64(run_t, wo);
            wt_t  <= sat_addw(wt_t, WT_W'(w_r));
          end else begin
            run_c <= sat_add64(run_c, wo);
            wt_c  <= sat_addw(wt_c, WT_W'(w_r));
          end
          wt_all    <= sat_addw(wt_all, WT_W'(w_r));
          prev_up   <= up_r;
          have_prev <= 1'b1;
        end
        S_END: begin
          cph      <= 1'b0;
          ret_last <= 1'b1;
        end
        S_CGO: neg_r <= cs[ACC_W-1];
        S_CWAIT: begin
          if (mrsp.done) begin
            if (!cph) begin
              asum_t <= sat_add64(asum_t, cstep);
              cph    <= 1'b1;
            end else begin
              asum_c  <= sat_add64(asum_c, cstep);
              prev_t  <= run_t;
              prev_c  <= run_c;
              prev_gw <= wt_all;
            end
          end
        end
        S_FIN: begin
          fk       <= 3'd0;
          res_st   <= st_fin;
          res_area <= '0;
          res_qini <= '0;
        end
        S_FWAIT: begin
          if (mrsp.done) begin
            fk <= fk + 3'd1;
            case (fk)
              3'd0, 3'd2: den <= mres[DEN_W-1:0];
              3'd1: t_at <= signed_of(asum_t[ACC_W-1], wclamp(mres, TERM_MAX));
              3'd3: t_ac <= signed_of(asum_c[ACC_W-1], wclamp(mres, TERM_MAX));
              3'd4: t_lt <= signed_of(run_t[ACC_W-1], wclamp(mres, TERM_MAX));
              default: t_lc <= signed_of(run_c[ACC_W-1], wclamp(mres, TERM_MAX));
            endcase
          end
        end
        S_COMB: begin
          res_area <= $signed(sat32(area_c));
          res_qini <= $signed(sat32(qini_c));
        end
        S_EMIT: begin
          if (!out_valid) begin
            area      <= res_area;
            qini      <= res_qini;
            status    <= res_st;
            out_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (clear_now) begin
        wt_t      <= '0;
        wt_c      <= '0;
        wt_all    <= '0;
        prev_gw   <= '0;
        run_t     <= '0;
        run_c     <= '0;
        prev_t    <= '0;
        prev_c    <= '0;
        asum_t    <= '0;
        asum_c    <= '0;
        prev_up   <= '0;
        have_prev <= 1'b0;
        err       <= ST_OK;
      end
    end
  end

`ifndef SYNTHESIS
  // The sequencer never starts the shared unit while it is still working.
  a_mdu_idle_start: assert property (@(posedge clk) disable iff (rst)
    mreq.start |-> !mrsp.busy) else $error("shared unit started while busy");
  // No word accumulated yet means no weight has been summed.
  a_empty_stream: assert property (@(posedge clk) disable iff (rst)
    !have_prev |-> (wt_all == '0)) else $error("weight summed without a word");
  // A closed group can never hold more weight than the whole stream.
  a_group_weight: assert property (@(posedge clk) disable iff (rst)
    prev_gw <= wt_all) else $error("group weight above total weight");
`endif

endmodule

`default_nettype wire
